>>> rtl/core/lpr_pkg.sv
package lpr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int ERR_BITS    = COORD_BITS + 2;
  localparam int COLOR_BITS  = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0]        span_t;
  typedef logic [ERR_BITS-1:0]          err_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  // classified request as it travels from front to back
  typedef struct packed {
    action_e action;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
    span_t   span_x;
    span_t   span_y;
    logic    dir_x;
    logic    dir_y;
    color_t  color;
  } cmd_t;

endpackage

>>> rtl/core/line_pixel_rasterizer.sv
// Line rasterizer with one pixel per clock while the pixel sink does not stall. A load
// request (action 0) gives start point, end point and color; it yields the end pixel right
// away, flagged last when the line has zero length. Each step request (action 1) yields the
// next pixel of the walk from the start point toward the end point along the major axis,
// the one before the end point flagged last; steps with no line in progress yield nothing,
// and a load drops any line in progress. Requests are taken one per clock while the queue
// has room; the front classifies each accepted request into a two-entry queue, and the back
// handles it in its step unit (one compare and two parallel adds), then one output register.
module line_pixel_rasterizer
  import lpr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  // request channel
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  logic   action_i,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  input  color_t color_i,
  // pixel channel
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output coord_t pixel_x_o,
  output coord_t pixel_y_o,
  output color_t pixel_color_o,
  output logic   last_o
);

  cmd_t front_cmd;   // classified request, spans and directions worked out
  cmd_t queue_cmd;   // head of the queue
  logic queue_full;
  logic queue_valid;
  logic queue_pop;

  // front: spans, step directions, request kind
  lpr_front u_front (
    .action_i  (action_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .color_i   (color_i),
    .cmd_o     (front_cmd)
  );

  // short queue so a stalled pixel sink does not stall requests at once
  lpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // request accepted whenever the queue has room
  assign in_stall_o = queue_full;

  // back: walk state, error accumulator and output register
  lpr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (queue_valid),
    .q_cmd_i       (queue_cmd),
    .q_pop_o       (queue_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_o        (last_o)
  );

endmodule

>>> rtl/core/lpr_front.sv
module lpr_front
  import lpr_pkg::*;
(
  input  logic   action_i,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  input  color_t color_i,
  output cmd_t   cmd_o
);

  logic [COORD_BITS:0] diff_x;
  logic [COORD_BITS:0] diff_y;
  logic [COORD_BITS:0] neg_x;
  logic [COORD_BITS:0] neg_y;
  logic                dir_x;
  logic                dir_y;

  // sign-extended deltas, one bit wider than a coordinate
  assign diff_x = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
  assign diff_y = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
  assign neg_x  = -diff_x;
  assign neg_y  = -diff_y;

  // equal coordinates count as stepping toward smaller values
  assign dir_x = !(start_x_i < end_x_i);
  assign dir_y = !(start_y_i < end_y_i);

  always_comb begin
    cmd_o.action  = action_e'(action_i);
    cmd_o.start_x = start_x_i;
    cmd_o.start_y = start_y_i;
    cmd_o.end_x   = end_x_i;
    cmd_o.end_y   = end_y_i;
    cmd_o.span_x  = dir_x ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
    cmd_o.span_y  = dir_y ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];
    cmd_o.dir_x   = dir_x;
    cmd_o.dir_y   = dir_y;
    cmd_o.color   = color_i;
  end

endmodule

>>> rtl/core/lpr_queue.sv
module lpr_queue
  import lpr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_BITS'(1);
      2'b01:   count_d = count_q - CNT_BITS'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/core/lpr_back.sv
module lpr_back
  import lpr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  cmd_t   q_cmd_i,
  output logic   q_pop_o,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output coord_t pixel_x_o,
  output coord_t pixel_y_o,
  output color_t pixel_color_o,
  output logic   last_o
);

  // walk state
  coord_t                pos_x_q, pos_x_d;
  coord_t                pos_y_q, pos_y_d;
  coord_t                stop_x_q, stop_x_d;
  coord_t                stop_y_q, stop_y_d;
  err_t                  err_q, err_d;
  span_t                 thresh_q, thresh_d;
  logic [COORD_BITS:0]   inc_q, inc_d;
  logic                  dir_x_q, dir_x_d;
  logic                  dir_y_q, dir_y_d;
  logic                  x_major_q, x_major_d;
  logic                  busy_q, busy_d;
  color_t                pen_q, pen_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  coord_t                out_x_q, out_x_d;
  coord_t                out_y_q, out_y_d;
  color_t                out_color_q, out_color_d;
  logic                  out_last_q, out_last_d;

  logic                  adv;
  logic                  pop;
  logic                  emit;
  logic                  ld_x_major;
  logic                  ld_busy;
  span_t                 ld_minor;
  logic                  err_hit;
  coord_t                step_x;
  coord_t                step_y;
  logic                  step_done;

  assign adv     = !out_valid_q || !out_stall_i;
  assign pop     = q_valid_i && adv;
  assign q_pop_o = pop;

  // load: ties walk along y
  assign ld_x_major = q_cmd_i.span_x > q_cmd_i.span_y;
  assign ld_busy    = (q_cmd_i.span_x != '0) || (q_cmd_i.span_y != '0);
  assign ld_minor   = ld_x_major ? q_cmd_i.span_y : q_cmd_i.span_x;

  // step: err + minor + 1 >= major + 1 reduces to err >= major - minor
  assign err_hit   = (err_q >= ERR_BITS'(thresh_q));
  assign step_x    = dir_x_q ? pos_x_q - coord_t'(1) : pos_x_q + coord_t'(1);
  assign step_y    = dir_y_q ? pos_y_q - coord_t'(1) : pos_y_q + coord_t'(1);
  assign step_done = x_major_q ? (step_x == stop_x_q) : (step_y == stop_y_q);

  always_comb begin
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    stop_x_d    = stop_x_q;
    stop_y_d    = stop_y_q;
    err_d       = err_q;
    thresh_d    = thresh_q;
    inc_d       = inc_q;
    dir_x_d     = dir_x_q;
    dir_y_d     = dir_y_q;
    x_major_d   = x_major_q;
    busy_d      = busy_q;
    pen_d       = pen_q;
    emit        = 1'b0;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;
    if (pop) begin
      unique case (q_cmd_i.action)
        ACT_LOAD: begin
          pos_x_d     = q_cmd_i.start_x;
          pos_y_d     = q_cmd_i.start_y;
          stop_x_d    = q_cmd_i.end_x;
          stop_y_d    = q_cmd_i.end_y;
          err_d       = '0;
          thresh_d    = ld_x_major ? q_cmd_i.span_x - q_cmd_i.span_y
                                   : q_cmd_i.span_y - q_cmd_i.span_x;
          inc_d       = {1'b0, ld_minor} + (COORD_BITS+1)'(1);
          dir_x_d     = q_cmd_i.dir_x;
          dir_y_d     = q_cmd_i.dir_y;
          x_major_d   = ld_x_major;
          busy_d      = ld_busy;
          pen_d       = q_cmd_i.color;
          emit        = 1'b1;
          out_x_d     = q_cmd_i.end_x;
          out_y_d     = q_cmd_i.end_y;
          out_color_d = q_cmd_i.color;
          out_last_d  = !ld_busy;
        end
        ACT_STEP: begin
          if (busy_q) begin
            err_d       = err_hit ? err_q - ERR_BITS'(thresh_q) : err_q + ERR_BITS'(inc_q);
            pos_x_d     = (x_major_q || err_hit) ? step_x : pos_x_q;
            pos_y_d     = (!x_major_q || err_hit) ? step_y : pos_y_q;
            busy_d      = !step_done;
            emit        = 1'b1;
            out_x_d     = pos_x_q;
            out_y_d     = pos_y_q;
            out_color_d = pen_q;
            out_last_d  = step_done;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    out_valid_d = adv ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      stop_x_q    <= '0;
      stop_y_q    <= '0;
      err_q       <= '0;
      thresh_q    <= '0;
      inc_q       <= '0;
      dir_x_q     <= 1'b0;
      dir_y_q     <= 1'b0;
      x_major_q   <= 1'b0;
      pen_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      stop_x_q    <= stop_x_d;
      stop_y_q    <= stop_y_d;
      err_q       <= err_d;
      thresh_q    <= thresh_d;
      inc_q       <= inc_d;
      dir_x_q     <= dir_x_d;
      dir_y_q     <= dir_y_d;
      x_major_q   <= x_major_d;
      pen_q       <= pen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign pixel_color_o = out_color_q;
  assign last_o        = out_last_q;

  // accumulator stays below major + 1 while walking
  a_err_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (err_q < (ERR_BITS'(thresh_q) + ERR_BITS'(inc_q))))
    else $error("error accumulator out of range");

  // a dropped step leaves the output register empty
  a_drop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !emit) |=> !out_valid_q)
    else $error("dropped step left a result");

  // the final step of a walk ends the line
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && busy_q && (q_cmd_i.action == ACT_STEP) && step_done) |=> (!busy_q && out_last_q))
    else $error("walk did not end on last pixel");

endmodule
